### src/fcl_pkg.sv
`default_nettype none

package fcl_pkg;

    localparam int MAX_OUTPUTS_DEF  = 8;
    localparam int MAX_FEATURES_DEF = 16;
    localparam int MAX_BATCH_DEF    = 8;

    localparam int KIND_W   = 2;
    localparam int FIRST_W  = 4;
    localparam int SECOND_W = 5;
    localparam int VALUE_W  = 16;
    localparam int OROW_W   = 3;
    localparam int OCOL_W   = 3;

    localparam int ROWS_W  = 4;
    localparam int FEATS_W = 5;
    localparam int COLS_W  = 4;

    localparam logic [ROWS_W-1:0]  ROWS_RST  = 4'd8;
    localparam logic [FEATS_W-1:0] FEATS_RST = 5'd16;
    localparam logic [COLS_W-1:0]  COLS_RST  = 4'd8;

    localparam logic [KIND_W-1:0] KIND_WEIGHT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INPUT   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_COMPUTE = 2'd2;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 2;

    localparam logic [REG_IDX_W-1:0] REG_OUTPUT_ROWS    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_INPUT_FEATURES = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_BATCH_COLUMNS  = 2'd2;

    typedef struct packed {
        logic [ROWS_W-1:0]  output_rows;
        logic [FEATS_W-1:0] input_features;
        logic [COLS_W-1:0]  batch_columns;
    } fcl_cfg_t;

    // one store read issued by the controller
    typedef struct packed {
        logic valid;
        logic thr;   // threshold read, starts a new sum
        logic fin;   // final feature read of an element
        logic last;  // element is the last of the output matrix
    } fcl_rd_cmd_t;

    function automatic int idx_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

`default_nettype wire

### src/fcl_ifs.sv
`default_nettype none

interface fcl_in_if
    import fcl_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [KIND_W-1:0]          kind;
    logic [FIRST_W-1:0]         first_index;
    logic [SECOND_W-1:0]        second_index;
    logic signed [VALUE_W-1:0]  value;

    modport source (output valid, kind, first_index, second_index, value, input ready);
    modport sink   (input valid, kind, first_index, second_index, value, output ready);
endinterface

interface fcl_out_if
    import fcl_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [OROW_W-1:0]          out_row;
    logic [OCOL_W-1:0]          out_column;
    logic signed [VALUE_W-1:0]  out_value;
    logic                       saturated;
    logic                       last;

    modport source (output valid, out_row, out_column, out_value, saturated, last,
                    input ready);
    modport sink   (input valid, out_row, out_column, out_value, saturated, last,
                    output ready);
endinterface

`default_nettype wire

### src/fcl_regs.sv
`default_nettype none

module fcl_regs
    import fcl_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output fcl_cfg_t                   cfg
);

    fcl_cfg_t             cfg_reg;
    fcl_cfg_t             cfg_next;
    logic [REG_IDX_W-1:0] idx;
    logic                 wr;

    assign idx    = paddr[REG_IDX_W+1:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            case (idx)
                REG_OUTPUT_ROWS:    cfg_next.output_rows    = pwdata[ROWS_W-1:0];
                REG_INPUT_FEATURES: cfg_next.input_features = pwdata[FEATS_W-1:0];
                REG_BATCH_COLUMNS:  cfg_next.batch_columns  = pwdata[COLS_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_OUTPUT_ROWS:    prdata = APB_DATA_W'(cfg_reg.output_rows);
            REG_INPUT_FEATURES: prdata = APB_DATA_W'(cfg_reg.input_features);
            REG_BATCH_COLUMNS:  prdata = APB_DATA_W'(cfg_reg.batch_columns);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.output_rows    <= ROWS_RST;
            cfg_reg.input_features <= FEATS_RST;
            cfg_reg.batch_columns  <= COLS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

### src/fcl_ctrl.sv
`default_nettype none

module fcl_ctrl
    import fcl_pkg::*;
#(
    parameter int MAX_OUTPUTS  = MAX_OUTPUTS_DEF,
    parameter int MAX_FEATURES = MAX_FEATURES_DEF,
    parameter int MAX_BATCH    = MAX_BATCH_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire fcl_cfg_t          cfg,
    input  wire logic              in_valid,
    input  wire logic [KIND_W-1:0] in_kind,
    output logic                   in_ready,
    input  wire logic              busy,
    output fcl_rd_cmd_t            rd_cmd,
    output logic [idx_w(MAX_OUTPUTS)-1:0]  rd_row,
    output logic [idx_w(MAX_BATCH)-1:0]    rd_col,
    output logic [idx_w(MAX_FEATURES)-1:0] rd_feat
);

    localparam int RW = idx_w(MAX_OUTPUTS);
    localparam int BW = idx_w(MAX_BATCH);
    localparam int KW = idx_w(MAX_FEATURES);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WAIT = 2'd1;
    localparam logic [1:0] ST_THR  = 2'd2;
    localparam logic [1:0] ST_MAC  = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [RW-1:0] row_reg, row_next, rows_last_reg, rows_last_next;
    logic [BW-1:0] col_reg, col_next, cols_last_reg, cols_last_next;
    logic [KW-1:0] feat_reg, feat_next, feats_last_reg, feats_last_next;
    logic          fin;
    logic          last_elem;

    function automatic int clamp_count(input int v, input int mx);
        if (v == 0)
            return 1;
        if (v > mx)
            return mx;
        return v;
    endfunction

    assign in_ready  = (state_reg == ST_IDLE);
    assign fin       = (feat_reg == feats_last_reg);
    assign last_elem = (row_reg == rows_last_reg) && (col_reg == cols_last_reg);
    assign rd_row    = row_reg;
    assign rd_col    = col_reg;
    assign rd_feat   = feat_reg;

    always_comb
    begin
        state_next      = state_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        feat_next       = feat_reg;
        rows_last_next  = rows_last_reg;
        cols_last_next  = cols_last_reg;
        feats_last_next = feats_last_reg;
        rd_cmd          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_kind == KIND_COMPUTE)
                begin
                    rows_last_next  = RW'(clamp_count(int'(cfg.output_rows), MAX_OUTPUTS) - 1);
                    cols_last_next  = BW'(clamp_count(int'(cfg.batch_columns), MAX_BATCH) - 1);
                    feats_last_next = KW'(clamp_count(int'(cfg.input_features),
                                                      MAX_FEATURES) - 1);
                    row_next        = '0;
                    col_next        = '0;
                    state_next      = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (!busy)
                    state_next = ST_THR;
            end
            ST_THR:
            begin
                rd_cmd.valid = 1'b1;
                rd_cmd.thr   = 1'b1;
                feat_next    = '0;
                state_next   = ST_MAC;
            end
            ST_MAC:
            begin
                rd_cmd.valid = 1'b1;
                rd_cmd.fin   = fin;
                rd_cmd.last  = fin && last_elem;
                if (!fin)
                begin
                    feat_next = feat_reg + KW'(1);
                end
                else if (last_elem)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_WAIT;
                    if (col_reg == cols_last_reg)
                    begin
                        col_next = '0;
                        row_next = row_reg + RW'(1);
                    end
                    else
                    begin
                        col_next = col_reg + BW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            row_reg        <= '0;
            col_reg        <= '0;
            feat_reg       <= '0;
            rows_last_reg  <= '0;
            cols_last_reg  <= '0;
            feats_last_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            feat_reg       <= feat_next;
            rows_last_reg  <= rows_last_next;
            cols_last_reg  <= cols_last_next;
            feats_last_reg <= feats_last_next;
        end
    end

endmodule

`default_nettype wire

### src/fcl_dp.sv
`default_nettype none

module fcl_dp
    import fcl_pkg::*;
#(
    parameter int MAX_OUTPUTS  = MAX_OUTPUTS_DEF,
    parameter int MAX_FEATURES = MAX_FEATURES_DEF,
    parameter int MAX_BATCH    = MAX_BATCH_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      wr_en,
    input  wire logic [KIND_W-1:0]         in_kind,
    input  wire logic [FIRST_W-1:0]        in_first,
    input  wire logic [SECOND_W-1:0]       in_second,
    input  wire logic signed [VALUE_W-1:0] in_value,
    input  wire fcl_rd_cmd_t               rd_cmd,
    input  wire logic [idx_w(MAX_OUTPUTS)-1:0]  rd_row,
    input  wire logic [idx_w(MAX_BATCH)-1:0]    rd_col,
    input  wire logic [idx_w(MAX_FEATURES)-1:0] rd_feat,
    output logic                           busy,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [OROW_W-1:0]              out_row,
    output logic [OCOL_W-1:0]              out_column,
    output logic signed [VALUE_W-1:0]      out_value,
    output logic                           saturated,
    output logic                           last
);

    localparam int RW      = idx_w(MAX_OUTPUTS);
    localparam int BW      = idx_w(MAX_BATCH);
    localparam int KW      = idx_w(MAX_FEATURES);
    localparam int CW      = $clog2(MAX_FEATURES + 1);
    localparam int W_DEPTH = 1 << (RW + CW);
    localparam int I_DEPTH = 1 << (KW + BW);
    localparam int PROD_W  = 2 * VALUE_W;
    localparam int ACC_W   = PROD_W + 1 + CW;
    localparam int Q_W     = ACC_W - 8;

    localparam logic signed [Q_W-1:0]     Q_MAX = Q_W'(32767);
    localparam logic signed [Q_W-1:0]     Q_MIN = Q_W'(-32768);
    localparam logic signed [VALUE_W-1:0] V_MAX = 16'sh7FFF;
    localparam logic signed [VALUE_W-1:0] V_MIN = 16'sh8000;

    logic [VALUE_W-1:0] wmem [W_DEPTH];
    logic [VALUE_W-1:0] imem [I_DEPTH];

    logic              w_we, i_we;
    logic [RW+CW-1:0]  w_waddr, w_raddr;
    logic [KW+BW-1:0]  i_waddr, i_raddr;
    logic [CW-1:0]     w_rcol;

    logic signed [VALUE_W-1:0] w_rdata_reg, i_rdata_reg;
    fcl_rd_cmd_t               s1_cmd_reg, s2_cmd_reg;
    logic [RW-1:0]             s1_row_reg, s2_row_reg, res_row_reg;
    logic [BW-1:0]             s1_col_reg, s2_col_reg, res_col_reg;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic                      res_pend_reg, res_last_reg;
    logic                      out_valid_reg;

    logic signed [ACC_W-1:0]   rnd;
    logic signed [Q_W-1:0]     q;
    logic                      sat_hi, sat_lo;
    logic signed [VALUE_W-1:0] res_value;

    assign w_we = wr_en && in_kind == KIND_WEIGHT &&
                  int'(in_first) < MAX_OUTPUTS && int'(in_second) <= MAX_FEATURES;
    assign i_we = wr_en && in_kind == KIND_INPUT &&
                  int'(in_first) < MAX_FEATURES && int'(in_second) < MAX_BATCH;
    assign w_waddr = {RW'(in_first), CW'(in_second)};
    assign i_waddr = {KW'(in_first), BW'(in_second)};
    assign w_rcol  = rd_cmd.thr ? '0 : CW'(rd_feat) + CW'(1);
    assign w_raddr = {rd_row, w_rcol};
    assign i_raddr = {rd_feat, rd_col};

    always_ff @(posedge clk)
    begin
        if (w_we)
            wmem[w_waddr] <= in_value;
        w_rdata_reg <= wmem[w_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (i_we)
            imem[i_waddr] <= in_value;
        i_rdata_reg <= imem[i_raddr];
    end

    // threshold enters as -(thr * 256), aligned to Q16.16
    always_comb
    begin
        if (s1_cmd_reg.thr)
            prod_next = -$signed({{8{w_rdata_reg[VALUE_W-1]}}, w_rdata_reg, 8'h00});
        else
            prod_next = w_rdata_reg * i_rdata_reg;
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (s2_cmd_reg.valid)
        begin
            if (s2_cmd_reg.thr)
                acc_next = ACC_W'(prod_reg);
            else
                acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    // round half up, then saturate
    assign rnd    = acc_reg + ACC_W'(128);
    assign q      = $signed(rnd[ACC_W-1:8]);
    assign sat_hi = q > Q_MAX;
    assign sat_lo = q < Q_MIN;

    always_comb
    begin
        if (sat_hi)
            res_value = V_MAX;
        else if (sat_lo)
            res_value = V_MIN;
        else
            res_value = q[VALUE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_cmd_reg    <= '0;
            s2_cmd_reg    <= '0;
            res_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_cmd_reg   <= rd_cmd;
            s2_cmd_reg   <= s1_cmd_reg;
            res_pend_reg <= s2_cmd_reg.valid && s2_cmd_reg.fin;
            if (res_pend_reg)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_row_reg <= rd_row;
        s1_col_reg <= rd_col;
        s2_row_reg <= s1_row_reg;
        s2_col_reg <= s1_col_reg;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        if (s2_cmd_reg.valid && s2_cmd_reg.fin)
        begin
            res_row_reg  <= s2_row_reg;
            res_col_reg  <= s2_col_reg;
            res_last_reg <= s2_cmd_reg.last;
        end
        if (res_pend_reg)
        begin
            out_row    <= OROW_W'(res_row_reg);
            out_column <= OCOL_W'(res_col_reg);
            out_value  <= res_value;
            saturated  <= sat_hi || sat_lo;
            last       <= res_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign busy      = s1_cmd_reg.valid || s2_cmd_reg.valid || res_pend_reg || out_valid_reg;

endmodule

`default_nettype wire

### src/fully_connected_layer_forward_unit.sv
`default_nettype none

// Fully connected layer, forward pass, signed Q8.8. Weight words (kind 0) and input
// words (kind 1) each write one store entry when taken; out-of-range indexes are
// dropped. A compute word (kind 2) emits output_rows x batch_columns results (zero
// counts read as one, counts above the maximum clamp to it) in row-major order, each
// the feature sum of weight * input minus the row threshold, rounded half up to Q8.8
// and saturated. For each result the controller reads the threshold and then one
// feature per cycle through the single read port of each store, and waits for the
// multiply-accumulate pipeline to drain and the result register to be taken. Input
// ready drops from the compute word until the last feature read is issued. Both
// stores come up unwritten; no clearing pass follows reset. Write the configuration
// registers only while the block is idle.
module fully_connected_layer_forward_unit
    import fcl_pkg::*;
#(
    parameter int MAX_OUTPUTS  = MAX_OUTPUTS_DEF,
    parameter int MAX_FEATURES = MAX_FEATURES_DEF,
    parameter int MAX_BATCH    = MAX_BATCH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    fcl_in_if.sink                     items,
    fcl_out_if.source                  results,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int RW = idx_w(MAX_OUTPUTS);
    localparam int BW = idx_w(MAX_BATCH);
    localparam int KW = idx_w(MAX_FEATURES);

    fcl_cfg_t      cfg;
    fcl_rd_cmd_t   rd_cmd;
    logic [RW-1:0] rd_row;
    logic [BW-1:0] rd_col;
    logic [KW-1:0] rd_feat;
    logic          busy;
    logic          in_ready;
    logic          accept;

    assign items.ready = in_ready;
    assign accept      = items.valid && in_ready;

    fcl_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fcl_ctrl #(
        .MAX_OUTPUTS  (MAX_OUTPUTS),
        .MAX_FEATURES (MAX_FEATURES),
        .MAX_BATCH    (MAX_BATCH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (items.valid),
        .in_kind  (items.kind),
        .in_ready (in_ready),
        .busy     (busy),
        .rd_cmd   (rd_cmd),
        .rd_row   (rd_row),
        .rd_col   (rd_col),
        .rd_feat  (rd_feat)
    );

    fcl_dp #(
        .MAX_OUTPUTS  (MAX_OUTPUTS),
        .MAX_FEATURES (MAX_FEATURES),
        .MAX_BATCH    (MAX_BATCH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (accept),
        .in_kind    (items.kind),
        .in_first   (items.first_index),
        .in_second  (items.second_index),
        .in_value   (items.value),
        .rd_cmd     (rd_cmd),
        .rd_row     (rd_row),
        .rd_col     (rd_col),
        .rd_feat    (rd_feat),
        .busy       (busy),
        .out_valid  (results.valid),
        .out_ready  (results.ready),
        .out_row    (results.out_row),
        .out_column (results.out_column),
        .out_value  (results.out_value),
        .saturated  (results.saturated),
        .last       (results.last)
    );

endmodule

`default_nettype wire
